### sv/gnos_pkg.sv
// ----------------------------------------------------------------------------
// gnos_pkg
// Shared types and constants for the gradient noise octave sum block:
// item and result structs, power-chain link type, sequencer states, codes.
// ----------------------------------------------------------------------------
package gnos_pkg;

    // Item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHUNK_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_PERSISTENCE  = 2'd2;

    // Configuration reset values
    localparam logic [2:0]  OCTAVE_COUNT_RST = 3'd1;
    localparam logic [3:0]  CHUNK_SHIFT_RST  = 4'd4;
    localparam logic [15:0] PERSISTENCE_RST  = 16'd32768;

    // Fixed point: Q0.16 fractions, unity as 17 bits
    localparam int          FRAC_W    = 16;
    localparam logic [16:0] FRAC_ONE  = 17'd65536;

    // Cells in the fade power chain (t^2 .. t^5)
    localparam int POW_CELLS = 4;

    // Widths of the datapath words
    localparam int DOT_W   = 34;
    localparam int LERP_W  = 36;
    localparam int SCALE_W = 38;
    localparam int TOT_W   = 41;

    typedef struct packed {
        logic               mode;
        logic [1:0]         octave_index;
        logic [7:0]         grid_x;
        logic [7:0]         grid_y;
        logic signed [15:0] grad_cos;
        logic signed [15:0] grad_sin;
        logic [11:0]        point_x;
        logic [11:0]        point_y;
    } item_t;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic [7:0]         gray_level;
        logic               out_of_range;
    } result_t;

    // One link of the power chain: fraction and running power, both lanes
    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] px;
        logic [15:0] ty;
        logic [15:0] py;
    } pow_link_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SETUP,
        ST_ROW,
        ST_READ,
        ST_LERP_TOP,
        ST_LERP_BOT,
        ST_LERP_VAL,
        ST_SCALE,
        ST_ACC,
        ST_FINISH
    } state_t;

endpackage

### sv/gradient_noise_octave_sum.sv
// ----------------------------------------------------------------------------
// gradient_noise_octave_sum
// Two-dimensional gradient noise summed over octaves, with a gradient table.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low. A load item writes one corner
//   gradient into the table if it lies on the lattice and returns nothing;
//   busy is high for 1 cycle, and no item is accepted while it is. A sample
//   item returns one result on result with result_valid high for one cycle.
//   Each octave steps through setup, row address, the read states (the four
//   corner reads through the single table port and the dot products behind
//   them), three passes of the shared lerp unit, scale and accumulate. The
//   strobe is high in the cycle in which busy falls, and no item is
//   accepted before then. A point outside the map or zero octaves skips
//   the octaves and goes straight to the finish state.
//   The fade comes from a row of power cells that settles within the octave.
//   Registers are written on the cfg channel (cfg_ready is always high); the
//   user must write them only while the block is idle, which the block itself
//   does not enforce. Reset returns the registers to their defaults and the
//   sequencer to idle; the gradient table is not cleared and must be loaded
//   before use. The receiver takes every result in the cycle it appears.
// ----------------------------------------------------------------------------
module gradient_noise_octave_sum #(
    parameter int MAP_CELLS       = 16,
    parameter int MAX_OCTAVES     = 4,
    parameter int MAX_CHUNK_SHIFT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gnos_pkg::item_t   item,
    output logic              result_valid,
    output gnos_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    function automatic int unsigned side_of(input int unsigned o);
        return (MAP_CELLS << o) + 1;
    endfunction

    function automatic int unsigned base_of(input int unsigned o);
        int unsigned acc;
        acc = 0;
        for (int unsigned k = 0; k < MAX_OCTAVES; k++)
        begin
            if (k < o)
                acc = acc + side_of(k) * side_of(k);
        end
        return acc;
    endfunction

    localparam int DEPTH = base_of(MAX_OCTAVES);
    localparam int AW    = $clog2(DEPTH);
    localparam int CXW   = $clog2(MAP_CELLS << (MAX_OCTAVES - 1)) + 1;

    // Configuration
    logic [2:0]  octave_count_reg;
    logic [3:0]  chunk_shift_reg;
    logic [15:0] persistence_reg;
    logic [2:0]  oc_eff;
    logic [3:0]  cs_eff;

    // Sequencer
    gnos_pkg::state_t state_reg;
    gnos_pkg::state_t state_next;
    logic             accept;
    logic             out_of_map;

    // Datapath
    gnos_pkg::item_t          item_reg;
    logic                     oor_reg;
    logic [2:0]               o_reg;
    logic [16:0]              amp_reg;
    logic signed [gnos_pkg::TOT_W-1:0]   total_reg;
    logic [CXW-1:0]           cx_reg;
    logic [CXW-1:0]           cy_reg;
    logic [15:0]              fx_reg;
    logic [15:0]              fy_reg;
    logic [AW-1:0]            i00_reg;
    logic [AW-1:0]            side_reg;
    logic [2:0]               rd_cnt_reg;
    logic [31:0]              rdata_reg;
    logic signed [32:0]       pc_reg;
    logic signed [32:0]       ps_reg;
    logic [1:0]               pcorner_reg;
    logic signed [gnos_pkg::DOT_W-1:0]   dot_reg [4];
    logic signed [gnos_pkg::LERP_W-1:0]  top_reg;
    logic signed [gnos_pkg::LERP_W-1:0]  bot_reg;
    logic signed [gnos_pkg::LERP_W-1:0]  val_reg;
    logic signed [gnos_pkg::SCALE_W-1:0] scaled_reg;
    gnos_pkg::result_t        result_reg;
    gnos_pkg::result_t        result_next;
    logic                     result_valid_reg;

    // Gradient table
    logic [31:0]   mem [DEPTH];
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic          rd_en;
    logic [AW-1:0] raddr;

    // Combinational helpers
    logic [3:0]         shift_amt;
    logic [CXW-1:0]     cx_calc;
    logic [CXW-1:0]     cy_calc;
    logic [15:0]        fx_calc;
    logic [15:0]        fy_calc;
    logic [11:0]        frac_mask;
    logic [27:0]        frac_x_wide;
    logic [27:0]        frac_y_wide;
    logic [11+MAX_OCTAVES:0] px_up;
    logic [11+MAX_OCTAVES:0] py_up;
    int unsigned        load_side;
    int unsigned        load_addr;
    logic               load_ok;
    int unsigned        row_addr;
    logic [1:0]         corner;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [32:0] pc_calc;
    logic signed [32:0] ps_calc;
    logic [16:0]        fade_u;
    logic [16:0]        fade_v;
    logic signed [gnos_pkg::LERP_W-1:0] lerp_a;
    logic signed [gnos_pkg::LERP_W-1:0] lerp_b;
    logic [16:0]        lerp_w;
    logic signed [gnos_pkg::LERP_W:0]   lerp_diff;
    logic signed [54:0] lerp_prod;
    logic signed [38:0] lerp_sh;
    logic signed [38:0] lerp_sum;
    logic signed [gnos_pkg::LERP_W-1:0] lerp_res;
    logic signed [53:0] scale_prod;
    logic [32:0]        amp_prod;
    logic signed [24:0] nv_full;
    logic signed [15:0] nv_sat;
    logic signed [15:0] nv_clamp;
    logic [15:0]        gray_base;
    logic [23:0]        gray_prod;

    assign cfg_ready = 1'b1;
    assign oc_eff = (octave_count_reg > 3'(MAX_OCTAVES)) ? 3'(MAX_OCTAVES) : octave_count_reg;
    assign cs_eff = (chunk_shift_reg > 4'(MAX_CHUNK_SHIFT)) ? 4'(MAX_CHUNK_SHIFT)
                                                             : chunk_shift_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= gnos_pkg::OCTAVE_COUNT_RST;
            chunk_shift_reg  <= gnos_pkg::CHUNK_SHIFT_RST;
            persistence_reg  <= gnos_pkg::PERSISTENCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gnos_pkg::CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[2:0];
                gnos_pkg::CFG_CHUNK_SHIFT:  chunk_shift_reg  <= cfg_data[3:0];
                gnos_pkg::CFG_PERSISTENCE:  persistence_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept     = start && !busy;
    assign out_of_map = (32'(item.point_x) >= (32'(MAP_CELLS) << cs_eff))
                     || (32'(item.point_y) >= (32'(MAP_CELLS) << cs_eff));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gnos_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == gnos_pkg::MODE_LOAD)
                        state_next = gnos_pkg::ST_LOAD;
                    else if (out_of_map || oc_eff == 3'd0)
                        state_next = gnos_pkg::ST_FINISH;
                    else
                        state_next = gnos_pkg::ST_SETUP;
                end
            end
            gnos_pkg::ST_LOAD:     state_next = gnos_pkg::ST_IDLE;
            gnos_pkg::ST_SETUP:    state_next = gnos_pkg::ST_ROW;
            gnos_pkg::ST_ROW:      state_next = gnos_pkg::ST_READ;
            gnos_pkg::ST_READ:
            begin
                if (rd_cnt_reg == 3'd5)
                    state_next = gnos_pkg::ST_LERP_TOP;
            end
            gnos_pkg::ST_LERP_TOP: state_next = gnos_pkg::ST_LERP_BOT;
            gnos_pkg::ST_LERP_BOT: state_next = gnos_pkg::ST_LERP_VAL;
            gnos_pkg::ST_LERP_VAL: state_next = gnos_pkg::ST_SCALE;
            gnos_pkg::ST_SCALE:    state_next = gnos_pkg::ST_ACC;
            gnos_pkg::ST_ACC:
            begin
                if (o_reg + 3'd1 < oc_eff)
                    state_next = gnos_pkg::ST_SETUP;
                else
                    state_next = gnos_pkg::ST_FINISH;
            end
            gnos_pkg::ST_FINISH:   state_next = gnos_pkg::ST_IDLE;
            default:               state_next = gnos_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gnos_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == gnos_pkg::ST_FINISH);
        end
    end

    assign busy = (state_reg != gnos_pkg::ST_IDLE);

    // Load address and lattice check
    always_comb
    begin
        load_side = side_of(32'(item_reg.octave_index));
        load_ok   = (32'(item_reg.octave_index) < MAX_OCTAVES)
                 && (32'(item_reg.grid_x) < load_side)
                 && (32'(item_reg.grid_y) < load_side);
        load_addr = base_of(32'(item_reg.octave_index))
                  + 32'(item_reg.grid_y) * load_side + 32'(item_reg.grid_x);
        wr_en     = (state_reg == gnos_pkg::ST_LOAD) && load_ok;
        waddr     = AW'(load_addr);
    end

    // Cell position and fraction for the current octave
    always_comb
    begin
        shift_amt   = 4'd0;
        frac_mask   = 12'd0;
        frac_x_wide = 28'd0;
        frac_y_wide = 28'd0;
        px_up       = '0;
        py_up       = '0;
        cx_calc     = '0;
        cy_calc     = '0;
        fx_calc     = 16'd0;
        fy_calc     = 16'd0;
        if ({1'b0, o_reg} <= cs_eff)
        begin
            shift_amt   = cs_eff - {1'b0, o_reg};
            frac_mask   = (12'd1 << shift_amt) - 12'd1;
            cx_calc     = CXW'(item_reg.point_x >> shift_amt);
            cy_calc     = CXW'(item_reg.point_y >> shift_amt);
            frac_x_wide = {item_reg.point_x & frac_mask, 16'd0} >> shift_amt;
            frac_y_wide = {item_reg.point_y & frac_mask, 16'd0} >> shift_amt;
            fx_calc     = frac_x_wide[15:0];
            fy_calc     = frac_y_wide[15:0];
        end
        else
        begin
            shift_amt = {1'b0, o_reg} - cs_eff;
            px_up     = {{MAX_OCTAVES{1'b0}}, item_reg.point_x} << shift_amt;
            py_up     = {{MAX_OCTAVES{1'b0}}, item_reg.point_y} << shift_amt;
            cx_calc   = CXW'(px_up);
            cy_calc   = CXW'(py_up);
        end
        row_addr = base_of(32'(o_reg)) + 32'(cy_reg) * side_of(32'(o_reg)) + 32'(cx_reg);
    end

    // Corner read address and dot products
    always_comb
    begin
        rd_en = (state_reg == gnos_pkg::ST_READ) && (rd_cnt_reg < 3'd4);
        case (rd_cnt_reg[1:0])
            2'd0:    raddr = i00_reg;
            2'd1:    raddr = i00_reg + AW'(1);
            2'd2:    raddr = i00_reg + side_reg;
            default: raddr = i00_reg + side_reg + AW'(1);
        endcase
        corner  = 2'(rd_cnt_reg - 3'd1);
        dx      = corner[0] ? {1'b1, fx_reg} : {1'b0, fx_reg};
        dy      = corner[1] ? {1'b1, fy_reg} : {1'b0, fy_reg};
        pc_calc = $signed(rdata_reg[15:0]) * dx;
        ps_calc = $signed(rdata_reg[31:16]) * dy;
    end

    // Table storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= {item_reg.grad_sin, item_reg.grad_cos};
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    gnos_fade_chain u_fade (
        .clk    (clk),
        .tx     (fx_reg),
        .ty     (fy_reg),
        .fade_u (fade_u),
        .fade_v (fade_v)
    );

    // Shared lerp unit, scale product and next amplitude
    always_comb
    begin
        case (state_reg)
            gnos_pkg::ST_LERP_TOP:
            begin
                lerp_a = gnos_pkg::LERP_W'(dot_reg[0]);
                lerp_b = gnos_pkg::LERP_W'(dot_reg[1]);
                lerp_w = fade_u;
            end
            gnos_pkg::ST_LERP_BOT:
            begin
                lerp_a = gnos_pkg::LERP_W'(dot_reg[2]);
                lerp_b = gnos_pkg::LERP_W'(dot_reg[3]);
                lerp_w = fade_u;
            end
            default:
            begin
                lerp_a = top_reg;
                lerp_b = bot_reg;
                lerp_w = fade_v;
            end
        endcase
        lerp_diff = lerp_b - lerp_a;
        lerp_prod = lerp_diff * $signed({1'b0, lerp_w});
        lerp_sh   = lerp_prod[54:16];
        lerp_sum  = lerp_a + lerp_sh;
        lerp_res  = lerp_sum[gnos_pkg::LERP_W-1:0];
        scale_prod = val_reg * $signed({1'b0, amp_reg});
        amp_prod   = amp_reg * persistence_reg;
    end

    // Saturate the sum and build the gray byte
    always_comb
    begin
        nv_full = total_reg[gnos_pkg::TOT_W-1:16];
        if (nv_full > 25'sd32767)
            nv_sat = 16'sd32767;
        else if (nv_full < -25'sd32768)
            nv_sat = -16'sd32768;
        else
            nv_sat = nv_full[15:0];
        if (nv_sat > 16'sd16384)
            nv_clamp = 16'sd16384;
        else if (nv_sat < -16'sd16384)
            nv_clamp = -16'sd16384;
        else
            nv_clamp = nv_sat;
        gray_base = nv_clamp + 16'sd16384;
        gray_prod = 24'(gray_base) * 24'd255;
        if (oor_reg)
            result_next = '{noise_value: 16'sd0, gray_level: 8'd0, out_of_range: 1'b1};
        else
            result_next = '{noise_value: nv_sat, gray_level: gray_prod[22:15],
                            out_of_range: 1'b0};
    end

    // Datapath registers, advanced by state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gnos_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_reg  <= item;
                    oor_reg   <= out_of_map;
                    o_reg     <= 3'd0;
                    amp_reg   <= gnos_pkg::FRAC_ONE;
                    total_reg <= '0;
                end
            end
            gnos_pkg::ST_SETUP:
            begin
                cx_reg <= cx_calc;
                cy_reg <= cy_calc;
                fx_reg <= fx_calc;
                fy_reg <= fy_calc;
            end
            gnos_pkg::ST_ROW:
            begin
                i00_reg    <= AW'(row_addr);
                side_reg   <= AW'(side_of(32'(o_reg)));
                rd_cnt_reg <= 3'd0;
            end
            gnos_pkg::ST_READ:
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
                if (rd_cnt_reg inside {[3'd1:3'd4]})
                begin
                    pc_reg      <= pc_calc;
                    ps_reg      <= ps_calc;
                    pcorner_reg <= corner;
                end
                if (rd_cnt_reg inside {[3'd2:3'd5]})
                    dot_reg[pcorner_reg] <= pc_reg + ps_reg;
            end
            gnos_pkg::ST_LERP_TOP: top_reg <= lerp_res;
            gnos_pkg::ST_LERP_BOT: bot_reg <= lerp_res;
            gnos_pkg::ST_LERP_VAL: val_reg <= lerp_res;
            gnos_pkg::ST_SCALE:    scaled_reg <= scale_prod[53:16];
            gnos_pkg::ST_ACC:
            begin
                total_reg <= total_reg + gnos_pkg::TOT_W'(scaled_reg);
                amp_reg   <= amp_prod[32:16];
                o_reg     <= o_reg + 3'd1;
            end
            gnos_pkg::ST_FINISH:   result_reg <= result_next;
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### sv/gnos_pow_cell.sv
// ----------------------------------------------------------------------------
// gnos_pow_cell
// One cell of the fade power chain: multiplies the incoming power by the
// fraction on both lanes and hands fraction and new power to the next cell.
// ----------------------------------------------------------------------------
module gnos_pow_cell (
    input  logic                 clk,
    input  gnos_pkg::pow_link_t  link_in,
    output gnos_pkg::pow_link_t  link_out
);

    logic [31:0]         prod_x;
    logic [31:0]         prod_y;
    gnos_pkg::pow_link_t link_reg;
    gnos_pkg::pow_link_t link_next;

    // Truncated Q0.16 product on each lane
    always_comb
    begin
        prod_x       = link_in.px * link_in.tx;
        prod_y       = link_in.py * link_in.ty;
        link_next.tx = link_in.tx;
        link_next.ty = link_in.ty;
        link_next.px = prod_x[31:16];
        link_next.py = prod_y[31:16];
    end

    // Hand off to the neighbor every cycle
    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

### sv/gnos_fade_chain.sv
// ----------------------------------------------------------------------------
// gnos_fade_chain
// Row of power cells producing t^2..t^5 for both fractions, then the quintic
// fade 6t^5 - 15t^4 + 10t^3 clamped to 0..1. The output settles once the
// fractions have passed through the power cells and the fade register.
// ----------------------------------------------------------------------------
module gnos_fade_chain (
    input  logic        clk,
    input  logic [15:0] tx,
    input  logic [15:0] ty,
    output logic [16:0] fade_u,
    output logic [16:0] fade_v
);

    gnos_pkg::pow_link_t links [gnos_pkg::POW_CELLS+1];
    logic [16:0]         fade_u_reg;
    logic [16:0]         fade_v_reg;

    function automatic logic [16:0] fade_mix(input logic [15:0] t3, input logic [15:0] t4,
                                            input logic [15:0] t5);
        logic signed [21:0] f;
        f = 22'sd6 * $signed({6'd0, t5}) - 22'sd15 * $signed({6'd0, t4})
            + 22'sd10 * $signed({6'd0, t3});
        if (f < 22'sd0)
            return 17'd0;
        else if (f > $signed({5'd0, gnos_pkg::FRAC_ONE}))
            return gnos_pkg::FRAC_ONE;
        else
            return f[16:0];
    endfunction

    // Feed the fraction as both multiplicand and first power
    assign links[0] = '{tx: tx, px: tx, ty: ty, py: ty};

    for (genvar i = 0; i < gnos_pkg::POW_CELLS; i++)
    begin : g_cell
        gnos_pow_cell u_cell (
            .clk      (clk),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    // Combine t^3, t^4, t^5 and register
    always_ff @(posedge clk)
    begin
        fade_u_reg <= fade_mix(links[2].px, links[3].px, links[4].px);
        fade_v_reg <= fade_mix(links[2].py, links[3].py, links[4].py);
    end

    assign fade_u = fade_u_reg;
    assign fade_v = fade_v_reg;

endmodule

### sv/gnos_checker.sv
// ----------------------------------------------------------------------------
// gnos_checker
// Port-level checks for the gradient noise octave sum block, bound to the
// top level.
// ----------------------------------------------------------------------------
module gnos_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input gnos_pkg::result_t result
);

    // An accepted item occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // A result only follows work in progress
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in progress");

    // Results are single-cycle strobes, never back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held or repeated");

    // Points off the map carry a zero value and zero gray level
    a_off_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_of_range |->
            result.noise_value == 16'sd0 && result.gray_level == 8'd0)
        else $error("off-map result carries data");

endmodule

bind gradient_noise_octave_sum gnos_checker u_gnos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### tb/sv/gnos_checker.sv
// ----------------------------------------------------------------------------
// gnos_scoreboard
// Watches the item, result and register channels of the gradient noise
// octave sum block, predicts every sample result from its own copy of the
// gradient table and registers, and compares field by field in order.
// ----------------------------------------------------------------------------
module gnos_scoreboard (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  gnos_pkg::item_t   item,
    input  logic              result_valid,
    input  gnos_pkg::result_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                pending,
    output int                errors,
    output int                checked
);

    localparam int GRID_CELLS  = 16;
    localparam int OCT_LIMIT   = 4;
    localparam int SHIFT_LIMIT = 8;
    localparam int GRID_WORDS  = 22244;

    logic [31:0]       grad_mem [0:GRID_WORDS-1];
    int unsigned       oct_cnt;
    int unsigned       shift_reg;
    int unsigned       persist;
    gnos_pkg::result_t noise_q[$];

    // First corner of an octave's lattice in the table
    function automatic int unsigned lattice_base(int unsigned o);
        int unsigned b;
        b = 0;
        for (int unsigned k = 0; k < o; k++)
            b += ((GRID_CELLS << k) + 1) * ((GRID_CELLS << k) + 1);
        return b;
    endfunction

    function automatic longint corner_dot(int unsigned idx, longint dx, longint dy);
        logic [31:0] w;
        w = (idx < GRID_WORDS) ? grad_mem[idx] : 32'd0;
        return longint'($signed(w[15:0])) * dx + longint'($signed(w[31:16])) * dy;
    endfunction

    function automatic longint fade_q16(longint t);
        longint t2, t3, t4, t5, f;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        t4 = (t3 * t) >>> 16;
        t5 = (t4 * t) >>> 16;
        f  = 6 * t5 - 15 * t4 + 10 * t3;
        if (f < 0)
            f = 0;
        if (f > 65536)
            f = 65536;
        return f;
    endfunction

    function automatic longint blend(longint a, longint b, longint u);
        return a + (((b - a) * u) >>> 16);
    endfunction

    // Sum the octaves for one sample point
    function automatic gnos_pkg::result_t predict_noise(gnos_pkg::item_t it);
        gnos_pkg::result_t r;
        int unsigned cs, oc, lim, cx, cy, sd, i00, s;
        longint      fx, fy, u, v, d00, d10, d01, d11, top, bot, val;
        longint      total, amp, nv, c;
        r     = '0;
        cs    = (shift_reg > SHIFT_LIMIT) ? SHIFT_LIMIT : shift_reg;
        oc    = (oct_cnt > OCT_LIMIT) ? OCT_LIMIT : oct_cnt;
        lim   = GRID_CELLS << cs;
        total = 0;
        amp   = 65536;
        if (it.point_x >= lim || it.point_y >= lim)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        for (int unsigned o = 0; o < oc; o++)
        begin
            if (o <= cs)
            begin
                s  = cs - o;
                cx = it.point_x >> s;
                cy = it.point_y >> s;
                fx = longint'((it.point_x & ((1 << s) - 1)) << (16 - s));
                fy = longint'((it.point_y & ((1 << s) - 1)) << (16 - s));
            end
            else
            begin
                cx = it.point_x << (o - cs);
                cy = it.point_y << (o - cs);
                fx = 0;
                fy = 0;
            end
            sd    = (GRID_CELLS << o) + 1;
            i00   = lattice_base(o) + cy * sd + cx;
            d00   = corner_dot(i00, fx, fy);
            d10   = corner_dot(i00 + 1, fx - 65536, fy);
            d01   = corner_dot(i00 + sd, fx, fy - 65536);
            d11   = corner_dot(i00 + sd + 1, fx - 65536, fy - 65536);
            u     = fade_q16(fx);
            v     = fade_q16(fy);
            top   = blend(d00, d10, u);
            bot   = blend(d01, d11, u);
            val   = blend(top, bot, v);
            total += (val * amp) >>> 16;
            amp   = (amp * longint'(persist)) >> 16;
        end
        nv = total >>> 16;
        if (nv > 32767)
            nv = 32767;
        if (nv < -32768)
            nv = -32768;
        c = nv;
        if (c > 16384)
            c = 16384;
        if (c < -16384)
            c = -16384;
        r.noise_value = nv[15:0];
        r.gray_level  = 8'(((c + 16384) * 255) / 32768);
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        for (int i = 0; i < GRID_WORDS; i++)
            grad_mem[i] = '0;
        errors  = 0;
        checked = 0;
    end

    assign pending = noise_q.size();

    // Check results, then take register writes and items
    always @(posedge clk or negedge rst_n)
    begin
        gnos_pkg::result_t want;
        int unsigned       sd;
        if (!rst_n)
        begin
            oct_cnt   = 32'(gnos_pkg::OCTAVE_COUNT_RST);
            shift_reg = 32'(gnos_pkg::CHUNK_SHIFT_RST);
            persist   = 32'(gnos_pkg::PERSISTENCE_RST);
            noise_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (noise_q.size() == 0)
                    flag_mismatch("unexpected result, noise_value", result.noise_value, 0);
                else
                begin
                    want = noise_q.pop_front();
                    checked++;
                    if (result.noise_value !== want.noise_value)
                        flag_mismatch("noise_value", result.noise_value, want.noise_value);
                    if (result.gray_level !== want.gray_level)
                        flag_mismatch("gray_level", result.gray_level, want.gray_level);
                    if (result.out_of_range !== want.out_of_range)
                        flag_mismatch("out_of_range", result.out_of_range, want.out_of_range);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gnos_pkg::CFG_OCTAVE_COUNT: oct_cnt   = 32'(cfg_data[2:0]);
                    gnos_pkg::CFG_CHUNK_SHIFT:  shift_reg = 32'(cfg_data[3:0]);
                    gnos_pkg::CFG_PERSISTENCE:  persist   = 32'(cfg_data);
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (item.mode == gnos_pkg::MODE_SAMPLE)
                    noise_q = {noise_q, predict_noise(item)};
                else
                begin
                    sd = (GRID_CELLS << item.octave_index) + 1;
                    if (item.grid_x < sd && item.grid_y < sd)
                        grad_mem[lattice_base(item.octave_index) + item.grid_y * sd
                                 + item.grid_x] = {item.grad_sin, item.grad_cos};
                end
            end
        end
    end

endmodule

### tb/sv/gradient_noise_octave_sum_tb.sv
// ----------------------------------------------------------------------------
// gradient_noise_octave_sum_tb
// Drives loads and samples into the gradient noise octave sum block under
// several register settings, loading every corner a sample will read first,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module gradient_noise_octave_sum_tb;

    localparam int          GRID_CELLS = 16;
    localparam int          GRID_WORDS = 22244;
    localparam int          QUIET_MAX  = 2000;
    localparam int          ITEM_GOAL  = 1250;
    localparam logic [1:0]  CFG_SPARE  = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    gnos_pkg::item_t   item;
    logic              result_valid;
    gnos_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;
    int                pending;
    int                errors;
    int                checked;

    int          quiet;
    int          idle_pct;
    int          n_items;
    int          n_loads;
    int          n_samples;
    int unsigned oc_now;
    int unsigned cs_now;
    bit          loaded [0:GRID_WORDS-1];

    gradient_noise_octave_sum u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gnos_scoreboard u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pending     (pending),
        .errors      (errors),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("gradient_noise_octave_sum_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic int unsigned lattice_base(int unsigned o);
        int unsigned b;
        b = 0;
        for (int unsigned k = 0; k < o; k++)
            b += ((GRID_CELLS << k) + 1) * ((GRID_CELLS << k) + 1);
        return b;
    endfunction

    function automatic logic [15:0] pick_grad();
        case ($urandom_range(0, 7))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // Hold start through the transfer; idle randomly before it
    task automatic send(gnos_pkg::item_t it);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        while (busy)
            @(negedge clk);
        n_items++;
    endtask

    task automatic send_load(int unsigned o, int unsigned gx, int unsigned gy);
        gnos_pkg::item_t it;
        int unsigned     sd;
        it              = gnos_pkg::item_t'({$urandom, $urandom, $urandom});
        it.mode         = gnos_pkg::MODE_LOAD;
        it.octave_index = o[1:0];
        it.grid_x       = gx[7:0];
        it.grid_y       = gy[7:0];
        it.grad_cos     = pick_grad();
        it.grad_sin     = pick_grad();
        send(it);
        n_loads++;
        sd = (GRID_CELLS << o) + 1;
        if (gx < sd && gy < sd)
            loaded[lattice_base(o) + gy * sd + gx] = 1'b1;
    endtask

    // Load any corner the sample would read, then send the sample
    task automatic sample_at(int unsigned px, int unsigned py);
        gnos_pkg::item_t it;
        int unsigned     cs, oc, cx, cy, sd;
        cs = (cs_now > 8) ? 8 : cs_now;
        oc = (oc_now > 4) ? 4 : oc_now;
        if (px < (GRID_CELLS << cs) && py < (GRID_CELLS << cs))
        begin
            for (int unsigned o = 0; o < oc; o++)
            begin
                cx = (o <= cs) ? (px >> (cs - o)) : (px << (o - cs));
                cy = (o <= cs) ? (py >> (cs - o)) : (py << (o - cs));
                sd = (GRID_CELLS << o) + 1;
                for (int unsigned dy = 0; dy < 2; dy++)
                    for (int unsigned dx = 0; dx < 2; dx++)
                        if (!loaded[lattice_base(o) + (cy + dy) * sd + cx + dx])
                            send_load(o, cx + dx, cy + dy);
            end
        end
        it         = gnos_pkg::item_t'({$urandom, $urandom, $urandom});
        it.mode    = gnos_pkg::MODE_SAMPLE;
        it.point_x = px[11:0];
        it.point_y = py[11:0];
        send(it);
        n_samples++;
    endtask

    // Let the block go idle before touching registers
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        while (!cfg_ready)
            @(negedge clk);
    endtask

    task automatic apply_setting(int unsigned oc, int unsigned cs, int unsigned pers);
        drain();
        write_reg(gnos_pkg::CFG_OCTAVE_COUNT, 16'(($urandom & 16'hFFF8) | oc));
        write_reg(gnos_pkg::CFG_CHUNK_SHIFT, 16'(($urandom & 16'hFFF0) | cs));
        write_reg(gnos_pkg::CFG_PERSISTENCE, 16'(pers));
        write_reg(CFG_SPARE, 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        oc_now = oc;
        cs_now = cs;
    endtask

    initial
    begin
        int unsigned set_oc [8];
        int unsigned set_cs [8];
        int unsigned set_pr [8];
        int unsigned lim, o, sd, roll;

        set_oc    = '{0, 4, 4, 7, 2, 3, 4, 1};
        set_cs    = '{4, 0, 8, 15, 3, 6, 2, 9};
        set_pr    = '{32768, 65535, 0, 65535, 40000, 12345, 50000, 1};
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = gnos_pkg::CFG_OCTAVE_COUNT;
        cfg_data  = '0;
        quiet     = 0;
        idle_pct  = 0;
        n_items   = 0;
        n_loads   = 0;
        n_samples = 0;
        oc_now    = 32'(gnos_pkg::OCTAVE_COUNT_RST);
        cs_now    = 32'(gnos_pkg::CHUNK_SHIFT_RST);
        for (int i = 0; i < GRID_WORDS; i++)
            loaded[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners of the map, edges, out of map, ignored and edge loads
        sample_at(0, 0);
        sample_at(255, 255);
        sample_at(255, 0);
        sample_at(17, 200);
        sample_at(256, 0);
        sample_at(0, 256);
        sample_at(4095, 4095);
        send_load(0, 17, 3);
        send_load(0, 255, 255);
        send_load(3, 129, 0);
        send_load(3, 128, 128);
        sample_at(128, 128);

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++)
        begin
            apply_setting(set_oc[p], set_cs[p], (p == 6) ? $urandom_range(0, 65535) : set_pr[p]);
            lim = GRID_CELLS << ((cs_now > 8) ? 8 : cs_now);
            while (n_items < (ITEM_GOAL * (p + 1)) / 8)
            begin
                idle_pct = (n_items < ITEM_GOAL / 3) ? 24 :
                           (n_items < (2 * ITEM_GOAL) / 3) ? 59 : 0;
                roll = $urandom_range(0, 99);
                o    = $urandom_range(0, 3);
                sd   = (GRID_CELLS << o) + 1;
                if (roll < 60)
                    sample_at($urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
                else if (roll < 70)
                    sample_at($urandom_range(0, 4095), $urandom_range(0, 4095));
                else if (roll < 90)
                    send_load(o, $urandom_range(0, sd - 1), $urandom_range(0, sd - 1));
                else
                    send_load(o, $urandom_range(sd, 255), $urandom_range(0, 255));
            end
        end

        // Wait for the last results to drain
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("covered %0d items: %0d gradient loads, %0d samples, %0d results checked",
                 n_items, n_loads, n_samples, checked);
        $display("eight register settings, zero and saturated octave and shift counts");
        if (errors == 0)
            $display("gradient_noise_octave_sum_tb: done, clean");
        else
            $display("gradient_noise_octave_sum_tb: done, errors");
        $finish;
    end

endmodule
